// ===== rtl/core/cpr_pkg.sv =====
package cpr_pkg;

	// Ring geometry. SLOTS must be a power of two between 4 and 65536.
	localparam int SLOTS      = 512;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam int SLOT_SHIFT = 3;                  // eight bytes per slot
	localparam int FREE_W     = 9;
	localparam int FREE_MAX   = (1 << FREE_W) - 1;
	localparam int CNT_W      = (SLOT_W > FREE_W) ? SLOT_W : FREE_W;
	localparam int WORD_W     = 32;
	localparam int ENTRY_W    = 2 * WORD_W;
	localparam int ADDR_W     = 32;

	localparam int IN_DATA_W  = 120;
	localparam int OUT_DATA_W = 112;

	typedef enum logic [1:0] {
		OP_RESET = 2'd0,
		OP_PUSH  = 2'd1,
		OP_POP   = 2'd2,
		OP_PEEK  = 2'd3
	} op_t;

	typedef struct packed {
		logic                 we;
		logic [SLOT_W-1:0]    waddr;
		logic [ENTRY_W-1:0]   wdata;
		logic                 re;
		logic [SLOT_W-1:0]    raddr;
	} ram_req_t;

	typedef struct packed {
		logic [FREE_W-1:0]    free_slots;
		logic [ADDR_W-1:0]    put_address;
		logic                 overflow;
		logic                 peek;
	} meta_t;

endpackage

// ===== rtl/core/cpr_ram.sv =====
module cpr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/cpr_ptr.sv =====
// Write and fence pointers, ring memory requests and the result fields
// that depend only on the pointers.
module cpr_ptr (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  cpr_pkg::op_t                 op,
	input  logic [cpr_pkg::WORD_W-1:0]   word_first,
	input  logic [cpr_pkg::WORD_W-1:0]   word_second,
	input  logic [cpr_pkg::FREE_W-1:0]   pop_count,
	input  logic [cpr_pkg::ADDR_W-1:0]   dma_get_address,
	input  logic [cpr_pkg::FREE_W-1:0]   slot_offset,
	input  logic [cpr_pkg::ADDR_W-1:0]   base_address,
	output cpr_pkg::ram_req_t            ram_req,
	output cpr_pkg::meta_t               meta
);

	logic [cpr_pkg::SLOT_W-1:0] write_q;
	logic [cpr_pkg::SLOT_W-1:0] fence_q;
	logic [cpr_pkg::SLOT_W-1:0] write_nxt;
	logic [cpr_pkg::SLOT_W-1:0] fence_nxt;
	logic [cpr_pkg::SLOT_W-1:0] free_raw;
	logic [cpr_pkg::CNT_W-1:0]  free_ext;
	logic [cpr_pkg::CNT_W-1:0]  pop_sum;
	logic [cpr_pkg::CNT_W-1:0]  peek_sum;
	logic [cpr_pkg::ADDR_W-1:0] get_diff;
	logic                       full;
	logic                       ovf_flag;
	logic                       peek_flag;
	logic [cpr_pkg::FREE_W-1:0] free_sat;
	logic [cpr_pkg::ADDR_W-1:0] put_addr;

	assign full     = (write_q == fence_q);
	assign pop_sum  = cpr_pkg::CNT_W'(fence_q) + cpr_pkg::CNT_W'(pop_count);
	assign get_diff = dma_get_address - base_address;
	assign peek_sum = cpr_pkg::CNT_W'(get_diff[cpr_pkg::SLOT_SHIFT +: cpr_pkg::SLOT_W])
		+ cpr_pkg::CNT_W'(slot_offset);

	always_comb begin
		write_nxt     = write_q;
		fence_nxt     = fence_q;
		ram_req.we    = 1'b0;
		ram_req.waddr = write_q;
		ram_req.wdata = {word_second, word_first};
		ram_req.re    = 1'b0;
		ram_req.raddr = peek_sum[cpr_pkg::SLOT_W-1:0];
		ovf_flag      = 1'b0;
		peek_flag     = 1'b0;
		case (op)
			cpr_pkg::OP_RESET: begin
				write_nxt = '0;
				fence_nxt = cpr_pkg::SLOT_W'(cpr_pkg::SLOTS - 1);
			end
			cpr_pkg::OP_PUSH: begin
				if (full) begin
					ovf_flag = 1'b1;
				end else begin
					ram_req.we = accept;
					write_nxt  = write_q + 1'b1;
				end
			end
			cpr_pkg::OP_POP: begin
				fence_nxt = pop_sum[cpr_pkg::SLOT_W-1:0];
			end
			cpr_pkg::OP_PEEK: begin
				ram_req.re = accept;
				peek_flag  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Free slots saturate when the ring is wider than the count field.
	assign free_raw = fence_nxt - write_nxt;
	assign free_ext = cpr_pkg::CNT_W'(free_raw);
	assign free_sat = (free_ext > cpr_pkg::CNT_W'(cpr_pkg::FREE_MAX))
		? cpr_pkg::FREE_W'(cpr_pkg::FREE_MAX) : free_ext[cpr_pkg::FREE_W-1:0];
	assign put_addr = base_address
		+ (cpr_pkg::ADDR_W'(write_nxt) << cpr_pkg::SLOT_SHIFT);

	assign meta = '{free_slots: free_sat, put_address: put_addr,
		overflow: ovf_flag, peek: peek_flag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_q <= '0;
			fence_q <= cpr_pkg::SLOT_W'(cpr_pkg::SLOTS - 1);
		end else if (accept) begin
			write_q <= write_nxt;
			fence_q <= fence_nxt;
		end
	end

	a_push_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == cpr_pkg::OP_PUSH && full |=> $stable(write_q) && $stable(fence_q))
		else $error("pointers moved on a dropped push");

	a_push_advances: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == cpr_pkg::OP_PUSH && !full
		|=> write_q == $past(write_q) + 1'b1 && $stable(fence_q))
		else $error("push did not advance the write pointer by one");

endmodule

// ===== rtl/core/command_push_ring.sv =====
// Channel  | Ports            | Contents
// ---------+------------------+-----------------------------------------------
// in       | s_axis_*         | one operation: op code in tuser, operands in tdata
// out      | m_axis_*         | one result per operation: counts, address, pair
// config   | cfg_wen/wdata    | base address of the ring memory
//
// One transfer is taken per cycle while s_axis_tready is high; the single port
// pair of the ring memory sets that rate. Reset clears the pointers and the
// base address; the ring contents are not cleared and no clearing pass runs.
// A stall on the output holds the result register, then the middle stage,
// and only then drops s_axis_tready.
module command_push_ring (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [31:0] word_first, [63:32] word_second, [72:64] pop_count,
	// [104:73] dma_get_address, [113:105] slot_offset, rest zero
	input  logic [cpr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// [1:0] op
	input  logic [1:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [8:0] free_slots, [40:9] put_address, [72:41] peek_first,
	// [104:73] peek_second, rest zero
	output logic [cpr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// [0] overflow_error
	output logic [0:0]                        m_axis_tuser,
	input  logic                              cfg_wen,
	input  logic [cpr_pkg::ADDR_W-1:0]        cfg_wdata
);

	logic [cpr_pkg::ADDR_W-1:0]  base_q;
	logic                        accept;
	cpr_pkg::ram_req_t           ram_req;
	cpr_pkg::meta_t              meta;
	logic [cpr_pkg::ENTRY_W-1:0] ram_rdata;

	logic                        valid_s1;
	cpr_pkg::meta_t              meta_s1;
	logic                        adv_s1;

	logic                        out_valid_q;
	logic [cpr_pkg::OUT_DATA_W-1:0] out_data_q;
	logic                        out_ovf_q;
	logic [cpr_pkg::ENTRY_W-1:0] peek_pair;

	// Write the configuration register only while idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wen) begin
			base_q <= cfg_wdata;
		end
	end

	// The middle stage moves on when the result register is empty or being taken;
	// a new transfer is taken whenever the middle stage will be free.
	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	cpr_ptr u_ptr (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.op              (cpr_pkg::op_t'(s_axis_tuser)),
		.word_first      (s_axis_tdata[31:0]),
		.word_second     (s_axis_tdata[63:32]),
		.pop_count       (s_axis_tdata[72:64]),
		.dma_get_address (s_axis_tdata[104:73]),
		.slot_offset     (s_axis_tdata[113:105]),
		.base_address    (base_q),
		.ram_req         (ram_req),
		.meta            (meta)
	);

	// A push writes at the accepting edge, so a peek taken in the next cycle at the
	// same slot already reads the new pair. The read data holds until the next
	// peek is accepted, which cannot happen before the middle stage moves on.
	cpr_ram #(
		.WIDTH (cpr_pkg::ENTRY_W),
		.DEPTH (cpr_pkg::SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta;
		end
	end

	// Peeked words are zero for every other operation.
	assign peek_pair = meta_s1.peek ? ram_rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= cpr_pkg::OUT_DATA_W'({peek_pair, meta_s1.put_address,
				meta_s1.free_slots});
			out_ovf_q  <= meta_s1.overflow;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_ovf_q;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(meta_s1))
		else $error("middle stage lost or changed a stalled result");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while both stages are stalled");

	a_ovf_not_peek: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && meta_s1.overflow |-> !meta_s1.peek)
		else $error("overflow flagged on a peek");

endmodule

// ===== tb/sv/command_push_ring_test.sv =====
`timescale 1ns / 100ps

module command_push_ring_test;

	// A cycle with no transfer on either side counts towards this limit.
	localparam int STALL_LIMIT = 2000;

	typedef struct {
		cpr_pkg::op_t                op;
		logic [cpr_pkg::WORD_W-1:0]  word_first;
		logic [cpr_pkg::WORD_W-1:0]  word_second;
		logic [8:0]                  pop_count;
		logic [cpr_pkg::ADDR_W-1:0]  get_addr;
		logic [8:0]                  slot_offset;
	} ring_cmd_t;

	typedef struct {
		logic [cpr_pkg::FREE_W-1:0]  free_slots;
		logic [cpr_pkg::ADDR_W-1:0]  put_address;
		logic [cpr_pkg::WORD_W-1:0]  peek_first;
		logic [cpr_pkg::WORD_W-1:0]  peek_second;
		logic                        overflow;
	} ring_res_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [cpr_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
	logic [1:0]                      s_axis_tuser = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [cpr_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
	logic [0:0]                      m_axis_tuser;
	logic                            cfg_wen = 1'b0;
	logic [cpr_pkg::ADDR_W-1:0]      cfg_wdata = '0;

	// Commands waiting for the driver, and results still owed by the block.
	ring_cmd_t                       cmd_pending[$];
	ring_res_t                       result_expect[$];
	ring_cmd_t                       drive_cmd;

	// Our own view of the ring: pointers, stored pairs and the base address.
	logic [cpr_pkg::SLOT_W-1:0]      pred_wr = '0;
	logic [cpr_pkg::SLOT_W-1:0]      pred_fence = '1;
	logic [cpr_pkg::ENTRY_W-1:0]     pred_mem [cpr_pkg::SLOTS];
	logic [cpr_pkg::ADDR_W-1:0]      pred_base = '0;

	// The stimulus side tracks the pointers too, so that it can steer the ring
	// into a full state and only peek at slots that have been filled.
	logic [cpr_pkg::SLOT_W-1:0]      plan_wr = '0;
	logic [cpr_pkg::SLOT_W-1:0]      plan_fence = '1;
	bit                              plan_written [cpr_pkg::SLOTS];
	logic [cpr_pkg::SLOT_W-1:0]      plan_filled[$];

	int                              send_idle_pct = 0;
	int                              recv_stall_pct = 0;
	int                              fault_count = 0;
	int                              quiet_cycles = 0;

	command_push_ring uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata)
	);

	always #1 clk = ~clk;

	// Applies one command to our copy of the ring and returns what the block
	// should answer. A full ring is one where the write and fence pointers meet.
	function automatic ring_res_t ring_apply(ring_cmd_t c);
		ring_res_t                   r;
		logic [cpr_pkg::ADDR_W-1:0]  diff;
		logic [cpr_pkg::SLOT_W-1:0]  idx;
		r = '{default: '0};
		case (c.op)
			cpr_pkg::OP_RESET: begin
				pred_wr = '0;
				pred_fence = '1;
			end
			cpr_pkg::OP_PUSH: begin
				if (pred_wr == pred_fence) begin
					r.overflow = 1'b1;
				end else begin
					pred_mem[pred_wr] = {c.word_second, c.word_first};
					pred_wr = pred_wr + 1'b1;
				end
			end
			cpr_pkg::OP_POP: begin
				pred_fence = pred_fence + c.pop_count;
			end
			cpr_pkg::OP_PEEK: begin
				// Only bits [11:3] of the offset from the base select the slot; the
				// low three bits of an address off a slot boundary are dropped.
				diff = c.get_addr - pred_base;
				idx = diff[11:3] + c.slot_offset;
				{r.peek_second, r.peek_first} = pred_mem[idx];
			end
			default: ;
		endcase
		r.free_slots = pred_fence - pred_wr;
		r.put_address = pred_base + cpr_pkg::ADDR_W'({pred_wr, 3'b000});
		return r;
	endfunction

	function automatic ring_cmd_t noise_cmd(cpr_pkg::op_t op);
		ring_cmd_t c;
		c.op = op;
		c.word_first = $urandom;
		c.word_second = $urandom;
		c.pop_count = 9'($urandom_range(511));
		c.get_addr = $urandom;
		c.slot_offset = 9'($urandom_range(511));
		return c;
	endfunction

	task automatic enqueue_cmd(ring_cmd_t c);
		case (c.op)
			cpr_pkg::OP_RESET: begin
				plan_wr = '0;
				plan_fence = '1;
			end
			cpr_pkg::OP_PUSH: begin
				if (plan_wr != plan_fence) begin
					if (!plan_written[plan_wr]) begin
						plan_written[plan_wr] = 1'b1;
						plan_filled.push_back(plan_wr);
					end
					plan_wr = plan_wr + 1'b1;
				end
			end
			cpr_pkg::OP_POP: plan_fence = plan_fence + c.pop_count;
			default: ;
		endcase
		cmd_pending.push_back(c);
	endtask

	task automatic push_pair(logic [cpr_pkg::WORD_W-1:0] w1, logic [cpr_pkg::WORD_W-1:0] w2);
		ring_cmd_t c;
		c = noise_cmd(cpr_pkg::OP_PUSH);
		c.word_first = w1;
		c.word_second = w2;
		enqueue_cmd(c);
	endtask

	task automatic pop_slots(logic [8:0] n);
		ring_cmd_t c;
		c = noise_cmd(cpr_pkg::OP_POP);
		c.pop_count = n;
		enqueue_cmd(c);
	endtask

	// Builds a get address that lands on the given slot once the offset is
	// added: random upper bits, the slot bits, and the given bits below a slot.
	task automatic peek_slot(logic [cpr_pkg::SLOT_W-1:0] target, logic [8:0] soff,
		logic [2:0] lo);
		ring_cmd_t                   c;
		logic [cpr_pkg::SLOT_W-1:0]  rel;
		logic [31:0]                 hi;
		c = noise_cmd(cpr_pkg::OP_PEEK);
		hi = $urandom;
		rel = target - soff;
		c.slot_offset = soff;
		c.get_addr = pred_base + {hi[19:0], rel, lo};
		enqueue_cmd(c);
	endtask

	task automatic random_cmd();
		int                          k;
		logic [cpr_pkg::SLOT_W-1:0]  last;
		k = $urandom_range(99);
		last = plan_wr - 1'b1;
		if (k < 40) begin
			push_pair($urandom, $urandom);
		end else if (k < 68 && plan_filled.size() != 0) begin
			if ($urandom_range(1) && plan_written[last])
				peek_slot(last, 9'($urandom_range(511)), 3'($urandom_range(7)));
			else
				peek_slot(plan_filled[$urandom_range(plan_filled.size() - 1)],
					9'($urandom_range(511)), 3'($urandom_range(7)));
		end else if (k < 80) begin
			pop_slots(9'($urandom_range(12, 1)));
		end else if (k < 85) begin
			pop_slots(9'($urandom_range(511)));
		end else if (k < 94) begin
			// Moves the fence onto the write pointer, so the ring is full.
			pop_slots(plan_wr - plan_fence);
		end else begin
			enqueue_cmd(noise_cmd(cpr_pkg::OP_RESET));
		end
	endtask

	// Waits until the driver has nothing left and every result has come back.
	// The condition is sampled away from the rising edge, where it is settled.
	task automatic drain();
		while (cmd_pending.size() != 0 || s_axis_tvalid || result_expect.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_base(logic [cpr_pkg::ADDR_W-1:0] v);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		pred_base = v;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			fault_count++;
		end
	endtask

	// Driver: a command stays on the bus until its transfer; the next one is
	// driven at the edge of that transfer unless the sender chooses to idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				result_expect.push_back(ring_apply(drive_cmd));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (cmd_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drive_cmd = cmd_pending.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {6'b0, drive_cmd.slot_offset, drive_cmd.get_addr,
						drive_cmd.pop_count, drive_cmd.word_second, drive_cmd.word_first};
					s_axis_tuser <= drive_cmd.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transfer against the oldest expectation and
	// keeps the watchdog on cycles where neither side moves.
	always @(posedge clk or negedge arst_n) begin
		ring_res_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			quiet_cycles = 0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_expect.size() == 0) begin
					$error("result transfer with no command outstanding");
					fault_count++;
				end else begin
					want = result_expect.pop_front();
					check_field("free_slots", 32'(want.free_slots), 32'(m_axis_tdata[8:0]));
					check_field("put_address", want.put_address, m_axis_tdata[40:9]);
					check_field("peek_first", want.peek_first, m_axis_tdata[72:41]);
					check_field("peek_second", want.peek_second, m_axis_tdata[104:73]);
					check_field("overflow_error", 32'(want.overflow), 32'(m_axis_tuser[0]));
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [cpr_pkg::ADDR_W-1:0]  phase_base [6];
		int                          phase_mode [6];
		phase_base = '{32'hFFFF_FFFF, $urandom, 32'hFFFF_FFF8,
			$urandom & 32'hFFFF_FFF8, 32'h0000_0000, $urandom};
		phase_mode = '{0, 1, 2, 3, 1, 2};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the base set to 32'h8000_0000.
		write_base(32'h8000_0000);
		push_pair(32'h0000_0000, 32'h0000_0000);
		push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_pair($urandom, $urandom);
		peek_slot(0, 0, 0);
		peek_slot(1, 511, 7);
		peek_slot(2, 2, 3);
		pop_slots(0);
		pop_slots(511);
		// Fence onto the write pointer: the next pushes are dropped.
		pop_slots(plan_wr - plan_fence);
		push_pair($urandom, $urandom);
		push_pair($urandom, $urandom);
		pop_slots(1);
		push_pair($urandom, $urandom);
		push_pair($urandom, $urandom);
		peek_slot(3, 100, 3'($urandom_range(7)));
		// The reset command clears the pointers but the stored pairs survive.
		enqueue_cmd(noise_cmd(cpr_pkg::OP_RESET));
		peek_slot(1, 9'($urandom_range(511)), 3'($urandom_range(7)));
		push_pair($urandom, $urandom);
		peek_slot(0, 9'($urandom_range(511)), 3'($urandom_range(7)));
		// A pop far past the write pointer simply wraps the fence.
		pop_slots(300);
		push_pair($urandom, $urandom);
		peek_slot(plan_wr - 1'b1, 511, 0);
		drain();

		// Random phases, each setting its base address and idling pattern.
		for (int p = 0; p < 6; p++) begin
			write_base(phase_base[p]);
			case (phase_mode[p])
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 76;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 76;
				end
				default: begin
					send_idle_pct = 14;
					recv_stall_pct = 14;
				end
			endcase
			repeat (125) random_cmd();
			drain();
		end

		repeat (8) @(posedge clk);
		if (fault_count == 0 && result_expect.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== command_push_ring.f =====
rtl/core/cpr_pkg.sv
rtl/core/cpr_ram.sv
rtl/core/cpr_ptr.sv
rtl/core/command_push_ring.sv
tb/sv/command_push_ring_test.sv
